FILE: sv/sxfd_pkg.sv
// Shared types and constants for the start-of-frame XOR deframer.
`timescale 1ns / 1ps

package sxfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NodeW   = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned OutDataW = 88;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_SEED = 8'd1;

  // Result kinds carried on tuser.
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // Result fields as packed on tdata, last field in the lowest bits.
  typedef struct packed {
    logic [6:0]       pad;
    logic             frame_ok;
    logic [ByteW-1:0] sequence_number;
    logic [ByteW-1:0] payload_count;
    logic [ByteW-1:0] command_type;
    logic [ByteW-1:0] command_id;
    logic [ByteW-1:0] endpoint;
    logic [NodeW-1:0] node_id;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] payload_byte;
  } result_t;

endpackage

FILE: sv/sof_xor_frame_deframer.sv
// Payload and frame-end items are registered and appear in the cycle after their byte is taken.
// One byte per cycle unless the output stalls; the single output register refills as it drains.
// Header, check and phase updates are one compare, XOR and capture between the state registers.
// Reset (rst_ni low, asynchronous) returns to hunting, state at zero; output data is not reset.
// No clearing pass is needed; the block takes bytes in the first cycle after reset.
`timescale 1ns / 1ps

module sof_xor_frame_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sxfd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sxfd_pkg::ByteW-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sxfd_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] rx_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_length, [39:24] node_id,
  // [47:40] endpoint, [55:48] command_id, [63:56] command_type, [71:64] payload_count,
  // [79:72] sequence_number, [80] frame_ok, [87:81] zero
  output logic [sxfd_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser    // [0] result_kind
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_LEN, PH_NODE_HI, PH_NODE_LO, PH_EP, PH_ID, PH_TYPE,
    PH_PLEN, PH_PAYLOAD, PH_SEQ, PH_CHECK
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [sxfd_pkg::ByteW-1:0] start_byte_q, start_byte_d;
  logic [sxfd_pkg::ByteW-1:0] check_seed_q, check_seed_d;
  logic [sxfd_pkg::ByteW-1:0] bytes_left_q, bytes_left_d;
  logic [sxfd_pkg::ByteW-1:0] run_check_q, run_check_d;
  logic [sxfd_pkg::ByteW-1:0] length_q, length_d;
  logic [sxfd_pkg::NodeW-1:0] node_q, node_d;
  logic [sxfd_pkg::ByteW-1:0] endpoint_q, endpoint_d;
  logic [sxfd_pkg::ByteW-1:0] cmd_id_q, cmd_id_d;
  logic [sxfd_pkg::ByteW-1:0] cmd_type_q, cmd_type_d;
  logic [sxfd_pkg::ByteW-1:0] pcount_q, pcount_d;
  logic [sxfd_pkg::ByteW-1:0] seq_q, seq_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_kind_q, out_kind_d;
  sxfd_pkg::result_t          out_res_q, out_res_d;

  logic                       in_fire;
  logic                       res_valid;
  logic                       res_kind;
  sxfd_pkg::result_t          res;
  logic [sxfd_pkg::ByteW-1:0] b;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;
  assign m_axis_tuser  = out_kind_q;

  always_comb begin
    start_byte_d = start_byte_q;
    check_seed_d = check_seed_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sxfd_pkg::CFG_START_BYTE: start_byte_d = cfg_data_i;
        sxfd_pkg::CFG_CHECK_SEED: check_seed_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    run_check_d  = run_check_q;
    length_d     = length_q;
    node_d       = node_q;
    endpoint_d   = endpoint_q;
    cmd_id_d     = cmd_id_q;
    cmd_type_d   = cmd_type_q;
    pcount_d     = pcount_q;
    seq_d        = seq_q;
    res_valid    = 1'b0;
    res_kind     = sxfd_pkg::KIND_PAYLOAD;
    res          = '0;
    res.frame_length  = length_q;
    res.node_id       = node_q;
    res.endpoint      = endpoint_q;
    res.command_id    = cmd_id_q;
    res.command_type  = cmd_type_q;
    res.payload_count = pcount_q;
    if (in_fire) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == start_byte_q) begin
            run_check_d = check_seed_q;
            phase_d     = PH_LEN;
          end
        end
        PH_LEN: begin
          length_d = b;
          phase_d  = PH_NODE_HI;
        end
        PH_NODE_HI: begin
          node_d      = {b, node_q[sxfd_pkg::ByteW-1:0]};
          run_check_d = run_check_q ^ b;
          phase_d     = PH_NODE_LO;
        end
        PH_NODE_LO: begin
          node_d      = {node_q[sxfd_pkg::NodeW-1:sxfd_pkg::ByteW], b};
          run_check_d = run_check_q ^ b;
          phase_d     = PH_EP;
        end
        PH_EP: begin
          endpoint_d  = b;
          run_check_d = run_check_q ^ b;
          phase_d     = PH_ID;
        end
        PH_ID: begin
          cmd_id_d    = b;
          run_check_d = run_check_q ^ b;
          phase_d     = PH_TYPE;
        end
        PH_TYPE: begin
          cmd_type_d  = b;
          run_check_d = run_check_q ^ b;
          phase_d     = PH_PLEN;
        end
        PH_PLEN: begin
          pcount_d     = b;
          bytes_left_d = b;
          run_check_d  = run_check_q ^ b;
          phase_d      = (b == '0) ? PH_SEQ : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          run_check_d       = run_check_q ^ b;
          res_valid         = 1'b1;
          res.payload_byte  = b;
          res.payload_index = pcount_q - bytes_left_q;
          bytes_left_d      = bytes_left_q - 8'd1;
          if (bytes_left_q == 8'd1) begin
            phase_d = PH_SEQ;
          end
        end
        PH_SEQ: begin
          seq_d       = b;
          run_check_d = run_check_q ^ b;
          phase_d     = PH_CHECK;
        end
        PH_CHECK: begin
          res_valid           = 1'b1;
          res_kind            = sxfd_pkg::KIND_FRAME_END;
          res.sequence_number = seq_q;
          res.frame_ok        = (run_check_q == b) && (length_q != '0);
          phase_d             = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_res_d   = out_res_q;
    if (s_axis_tready) begin
      out_valid_d = in_fire && res_valid;
      out_kind_d  = res_kind;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      start_byte_q <= '0;
      check_seed_q <= '0;
      bytes_left_q <= '0;
      run_check_q  <= '0;
      length_q     <= '0;
      node_q       <= '0;
      endpoint_q   <= '0;
      cmd_id_q     <= '0;
      cmd_type_q   <= '0;
      pcount_q     <= '0;
      seq_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      start_byte_q <= start_byte_d;
      check_seed_q <= check_seed_d;
      bytes_left_q <= bytes_left_d;
      run_check_q  <= run_check_d;
      length_q     <= length_d;
      node_q       <= node_d;
      endpoint_q   <= endpoint_d;
      cmd_id_q     <= cmd_id_d;
      cmd_type_q   <= cmd_type_d;
      pcount_q     <= pcount_d;
      seq_q        <= seq_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_res_q  <= out_res_d;
  end

`ifndef SYNTH
  a_payload_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == sxfd_pkg::KIND_PAYLOAD)
      |-> out_res_q.payload_index < out_res_q.payload_count)
    else $error("payload index beyond payload count");

  a_payload_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == sxfd_pkg::KIND_PAYLOAD)
      |-> (out_res_q.frame_ok == 1'b0) && (out_res_q.sequence_number == '0))
    else $error("payload item carries frame-end fields");

  a_end_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == sxfd_pkg::KIND_FRAME_END)
      |-> (out_res_q.payload_byte == '0) && (out_res_q.payload_index == '0))
    else $error("frame-end item carries payload fields");

  a_hunt_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (phase_q == PH_HUNT) && (b != start_byte_q) |=> phase_q == PH_HUNT)
    else $error("left hunting on a non-start byte");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> bytes_left_q != '0)
    else $error("payload phase with no bytes left");
`endif

endmodule
